>>> rtl/hec_pkg.sv
// Shared types, constants and position helpers for the Hamming encoder/corrector.
// Self-contained; used by hec_core and hamming_encode_correct.
package hec_pkg;

  localparam int MAX_DATA_BITS = 57;
  localparam int WORD_BITS     = 63;
  localparam int POS_BITS      = 6;
  localparam int LEN_BITS      = 6;
  localparam int PAR_BITS      = 3;

  localparam logic [LEN_BITS-1:0] RESET_LEN = 6'd4;

  localparam logic KIND_ENCODE = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [MAX_DATA_BITS-1:0] data_word;
    logic [WORD_BITS-1:0]     received_word;
  } in_item_t;

  typedef struct packed {
    logic [WORD_BITS-1:0]     codeword;
    logic [POS_BITS-1:0]      error_position;
    logic                     error_found;
    logic [MAX_DATA_BITS-1:0] corrected_data;
  } out_item_t;

  // Settings derived from the data length once per write.
  typedef struct packed {
    logic [MAX_DATA_BITS-1:0] data_mask;
    logic [WORD_BITS-1:0]     word_mask;
    logic [POS_BITS-1:0]      word_len;
  } cfg_t;

  // Codeword position (1-based) of data bit k: the k-th position that is
  // not a power of two.
  function automatic int data_pos(input int k);
    int cnt;
    int res;
    cnt = 0;
    res = 0;
    for (int pos = 1; pos <= WORD_BITS; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (cnt == k) res = pos;
        cnt++;
      end
    end
    return res;
  endfunction

  // Word bits whose position has bit j set.
  function automatic logic [WORD_BITS-1:0] syn_col(input int j);
    logic [WORD_BITS-1:0] col;
    col = '0;
    for (int pos = 1; pos <= WORD_BITS; pos++) begin
      col[pos-1] = ((pos >> j) & 1) != 0;
    end
    return col;
  endfunction

  function automatic cfg_t cfg_of(input logic [LEN_BITS-1:0] len);
    logic [LEN_BITS-1:0] n;
    logic [PAR_BITS-1:0] p;
    cfg_t                c;
    if (len == '0) begin
      n = 6'd1;
    end else if (len > LEN_BITS'(MAX_DATA_BITS)) begin
      n = LEN_BITS'(MAX_DATA_BITS);
    end else begin
      n = len;
    end
    // Least p with 2^p >= n + p + 1; six passes on 7-bit values.
    p = 3'd1;
    for (int i = 0; i < 6; i++) begin
      if ((7'd1 << p) < (7'(n) + 7'(p) + 7'd1)) p = p + 3'd1;
    end
    c.word_len  = n + POS_BITS'(p);
    c.data_mask = {MAX_DATA_BITS{1'b1}} >> (LEN_BITS'(MAX_DATA_BITS) - n);
    c.word_mask = {WORD_BITS{1'b1}} >> (POS_BITS'(WORD_BITS) - c.word_len);
    return c;
  endfunction

endpackage

>>> rtl/hec_core.sv
// Combinational encode / syndrome / correct datapath for one word.
// Depends on hec_pkg for item types, config struct and position helpers.
module hec_core
  import hec_pkg::*;
(
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  logic [MAX_DATA_BITS-1:0] data_m;
  logic [WORD_BITS-1:0]     placed;
  logic [WORD_BITS-1:0]     rx_m;
  logic [WORD_BITS-1:0]     syn_in;
  logic [POS_BITS-1:0]      syn;
  logic [WORD_BITS-1:0]     par_vec;
  logic [WORD_BITS-1:0]     flip_vec;
  logic [WORD_BITS-1:0]     rx_fixed;
  logic [MAX_DATA_BITS-1:0] extracted;

  assign data_m = item.data_word & cfg.data_mask;
  assign rx_m   = item.received_word & cfg.word_mask;

  // Data bits map to fixed positions; parity slots stay zero here.
  always_comb begin
    placed = '0;
    for (int k = 0; k < MAX_DATA_BITS; k++) begin
      placed[data_pos(k)-1] = data_m[k];
    end
  end

  // One XOR tree serves both the encoder's parity and the decoder's syndrome.
  assign syn_in = (item.kind == KIND_DECODE) ? rx_m : placed;

  always_comb begin
    for (int j = 0; j < POS_BITS; j++) begin
      syn[j] = ^(syn_in & syn_col(j));
    end
  end

  always_comb begin
    par_vec = '0;
    for (int j = 0; j < POS_BITS; j++) begin
      par_vec[(1 << j) - 1] = syn[j];
    end
  end

  // A syndrome pointing past the codeword is reported but flips nothing.
  assign flip_vec = ((syn != '0) && (syn <= cfg.word_len)) ?
                    (WORD_BITS'(1) << (syn - POS_BITS'(1))) : '0;
  assign rx_fixed = rx_m ^ flip_vec;

  always_comb begin
    for (int k = 0; k < MAX_DATA_BITS; k++) begin
      extracted[k] = rx_fixed[data_pos(k)-1];
    end
  end

  always_comb begin
    result = '0;
    if (item.kind == KIND_DECODE) begin
      result.error_position = syn;
      result.error_found    = (syn != '0);
      result.corrected_data = extracted;
    end else begin
      result.codeword = placed | par_vec;
    end
  end

endmodule

>>> rtl/hamming_encode_correct.sv
// Hamming single-error-correcting encoder and decoder, top level.
// An accepted word passes the input register, then the result register, to the output;
// one word per cycle, busy stays low.
// The result strobe is high for one cycle per word and cannot be stalled.
// Synchronous active-low reset clears both valid flags and sets the data length to 4.
// Depends on hec_pkg and hec_core.
module hamming_encode_correct
  import hec_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  in_item_t            in_data,
  output logic                out_strobe,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LEN_BITS-1:0] cfg_data_length
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_strobe_r;
  out_item_t out_item_r;
  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  out_item_t result;
  logic      accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_nxt   = cfg_of(cfg_data_length);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= cfg_of(RESET_LEN);
    end else if (cfg_valid && cfg_ready) begin
      cfg_r <= cfg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      in_valid_r   <= accept;
      out_strobe_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item_r <= in_data;
    end
    if (in_valid_r) begin
      out_item_r <= result;
    end
  end

  hec_core u_core (
    .item   (in_item_r),
    .cfg    (cfg_r),
    .result (result)
  );

  assign out_strobe = out_strobe_r;
  assign out_data   = out_item_r;

  // Every accepted beat, with reset clear since, shows up as a result strobe.
  a_beat_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(rst_n, 2) && $past(accept, 2)) |-> out_strobe)
    else $error("accepted beat did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(rst_n)) |-> $past(accept, 2))
    else $error("result strobe without an accepted beat");

  a_flag_matches_syndrome: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.error_found == (out_data.error_position != '0)))
    else $error("error flag disagrees with syndrome");

  a_encode_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_data.codeword != '0)) |->
      (!out_data.error_found && (out_data.corrected_data == '0)))
    else $error("encode result carries decode fields");

  a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(cfg_valid && cfg_ready)) |->
      (cfg_r == cfg_of($past(cfg_data_length))))
    else $error("configuration write not applied");

endmodule
